// ===== sv/ramped_sine_nco_core_macros.svh =====
// Assertion macros for the ramped sine NCO core
`ifndef RAMPED_SINE_NCO_CORE_MACROS_SVH
`define RAMPED_SINE_NCO_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSN_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rsn assertion failed");
`define RSN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsn assertion failed");
`else
`define RSN_ASSERT(label, prop)
`define RSN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/rsn_pkg.sv =====
// Package: constants, types and constant tables of the ramped sine NCO
package rsn_pkg;

    localparam int unsigned INTENSITY_MAX  = 100;
    localparam int unsigned PEAK_AMPLITUDE = 32767;
    localparam int unsigned SINE_DEPTH     = 256;
    localparam int unsigned INT_DEPTH      = 128;

    localparam int unsigned AMP_W   = 17;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned INT_W   = 7;
    localparam int unsigned SMP_W   = 16;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [AMP_W-1:0]   AMP_ONE  = 17'h10000;
    localparam logic [AMP_W-1:0]   AMP_EPS  = 17'd33;
    localparam logic [31:0]        ENV_FULL = 32'd32767;
    localparam logic [PHASE_W-1:0] FSTEP_MIN = 32'd1;
    localparam logic [63:0]        PI_Q30   = 64'd3373259426;

    // register word indexes
    localparam logic [1:0] REG_RISE_STEP = 2'd0;
    localparam logic [1:0] REG_FALL_STEP = 2'd1;
    localparam logic [1:0] REG_INC_SLEW  = 2'd2;

    // ramp phase codes
    localparam logic [1:0] RAMP_IDLE = 2'd0;
    localparam logic [1:0] RAMP_UP   = 2'd1;
    localparam logic [1:0] RAMP_FALL = 2'd2;
    localparam logic [1:0] RAMP_SLEW = 2'd3;

    typedef struct packed {
        logic [AMP_W-1:0]   rise_step;
        logic [AMP_W-1:0]   fall_step;
        logic [PHASE_W-1:0] inc_slew;
    } cfg_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] rom;
        logic [15:0]             env;
        logic                    output_active;
        logic                    running;
        logic [1:0]              ramp_phase;
    } s1_t;

    typedef logic [SINE_DEPTH-1:0][SMP_W-1:0] sine_rom_t;
    typedef logic [INT_DEPTH-1:0][AMP_W-1:0]  amp_tbl_t;

    // sin(k*pi/128) in Q30, Taylor series, k in 0..64
    function automatic logic [63:0] quarter_sin_q30(input logic [6:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = ({57'd0, k} * PI_Q30 + 64'd64) >> 7;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd420;
        sum  = sum + term;
        return sum;
    endfunction

    function automatic sine_rom_t build_sine();
        logic [64:0][SMP_W-1:0] quarter;
        logic [63:0]            prod;
        logic [SMP_W-1:0]       v;
        sine_rom_t              rom;
        for (int k = 0; k <= 64; k++) begin
            if (k == 0) begin
                quarter[k] = '0;
            end
            else if (k == 64) begin
                quarter[k] = SMP_W'(PEAK_AMPLITUDE);
            end
            else begin
                prod       = quarter_sin_q30(7'(k)) * 64'(PEAK_AMPLITUDE);
                quarter[k] = SMP_W'(prod >> 30);
            end
        end
        for (int k = 0; k < int'(SINE_DEPTH); k++) begin
            v      = ((k % 128) <= 64) ? quarter[k % 128] : quarter[128 - (k % 128)];
            rom[k] = (k >= 128) ? SMP_W'(-v) : v;
        end
        return rom;
    endfunction

    // target amplitude in Q1.16 per intensity code, saturated at the maximum
    function automatic amp_tbl_t build_amp_tbl();
        amp_tbl_t    tbl;
        logic [31:0] c;
        for (int i = 0; i < int'(INT_DEPTH); i++) begin
            c      = (i > int'(INTENSITY_MAX)) ? INTENSITY_MAX : 32'(i);
            tbl[i] = AMP_W'((c * 32'd65536 + INTENSITY_MAX / 2) / INTENSITY_MAX);
        end
        return tbl;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam amp_tbl_t  AMP_TBL  = build_amp_tbl();

endpackage

// ===== sv/rsn_cfg_regs.sv =====
// APB configuration registers of the ramped sine NCO
module rsn_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsn_pkg::ADDR_W-1:0]    paddr,
    input  logic [rsn_pkg::DATA_W-1:0]    pwdata,
    output logic [rsn_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output rsn_pkg::cfg_t                 cfg
);

    rsn_pkg::cfg_t cfg_reg;
    rsn_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                rsn_pkg::REG_RISE_STEP: cfg_next.rise_step = pwdata[16:0];
                rsn_pkg::REG_FALL_STEP: cfg_next.fall_step = pwdata[16:0];
                rsn_pkg::REG_INC_SLEW:  cfg_next.inc_slew  = pwdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rsn_pkg::REG_RISE_STEP: prdata = {15'd0, cfg_reg.rise_step};
            rsn_pkg::REG_FALL_STEP: prdata = {15'd0, cfg_reg.fall_step};
            rsn_pkg::REG_INC_SLEW:  prdata = cfg_reg.inc_slew;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_step <= rsn_pkg::AMP_ONE;
            cfg_reg.fall_step <= rsn_pkg::AMP_ONE;
            cfg_reg.inc_slew  <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/rsn_ctrl.sv =====
// Envelope/frequency ramp control, phase accumulator and sine lookup stage
`include "ramped_sine_nco_core_macros.svh"
module rsn_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rsn_pkg::cfg_t                  cfg,
    input  logic                           accept,
    input  logic                           advance,
    input  logic                           action,
    input  logic                           run_request,
    input  logic [rsn_pkg::PHASE_W-1:0]    goal_inc,
    input  logic [rsn_pkg::INT_W-1:0]      goal_level,
    output logic                           s1_valid,
    output rsn_pkg::s1_t                   s1
);

    logic [rsn_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [rsn_pkg::PHASE_W-1:0] inc_reg, inc_next;
    logic [rsn_pkg::AMP_W-1:0]   amp_reg, amp_next;
    logic                        son_reg, son_next;
    logic                        em_reg, em_next;
    logic [1:0]                  code_reg, code_next;
    logic                        s1_valid_reg;
    rsn_pkg::s1_t                s1_reg, s1_next;

    logic [rsn_pkg::AMP_W-1:0]   tgt_amp, up_step, dn_step, amp1, amp_cl;
    logic [rsn_pkg::AMP_W:0]     amp_sum;
    logic [rsn_pkg::PHASE_W-1:0] inc0, inc1, fstep, inc_d, inc_s;
    logic [32:0]                 env_w;
    logic                        up, down, fneed, emit, son1;

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    always_comb
    begin
        tgt_amp = run_request ? rsn_pkg::AMP_TBL[goal_level] : '0;
        up_step = (cfg.rise_step == '0) ? rsn_pkg::AMP_ONE : cfg.rise_step;
        dn_step = (cfg.fall_step == '0) ? rsn_pkg::AMP_ONE : cfg.fall_step;
        fstep   = (cfg.inc_slew == '0) ? rsn_pkg::FSTEP_MIN : cfg.inc_slew;

        inc0 = (!run_request && amp_reg <= rsn_pkg::AMP_EPS && !son_reg)
               ? goal_inc : inc_reg;

        up    = {1'b0, tgt_amp} > ({1'b0, amp_reg} + {1'b0, rsn_pkg::AMP_EPS});
        down  = {1'b0, amp_reg} > ({1'b0, tgt_amp} + {1'b0, rsn_pkg::AMP_EPS});
        fneed = (goal_inc != inc0) && (run_request || son_reg);

        amp_sum = {1'b0, amp_reg} + {1'b0, up_step};
        if (amp_reg < tgt_amp)
            amp1 = (amp_sum > {1'b0, tgt_amp}) ? tgt_amp : amp_sum[rsn_pkg::AMP_W-1:0];
        else if (amp_reg > tgt_amp)
            amp1 = ((amp_reg - tgt_amp) > dn_step) ? (amp_reg - dn_step) : tgt_amp;
        else
            amp1 = amp_reg;

        inc_d = (inc0 < goal_inc) ? (goal_inc - inc0)
                                  : (inc0 - goal_inc);
        inc_s = (inc_d > fstep) ? fstep : inc_d;
        inc1  = (inc0 < goal_inc) ? (inc0 + inc_s) : (inc0 - inc_s);

        emit = (amp1 > rsn_pkg::AMP_EPS) && (inc1 != '0);
        son1 = son_reg || (run_request && tgt_amp > rsn_pkg::AMP_EPS
                           && goal_inc != '0) || emit;

        amp_cl = (amp_reg > rsn_pkg::AMP_ONE) ? rsn_pkg::AMP_ONE : amp_reg;
        env_w  = ({1'b0, amp_cl, 15'd0} - {16'd0, amp_cl}) + 33'd32768;

        phase_next = phase_reg;
        inc_next   = inc_reg;
        amp_next   = amp_reg;
        son_next   = son_reg;
        em_next    = em_reg;
        code_next  = code_reg;
        s1_next.rom = '0;

        if (action)
        begin
            amp_next  = amp1;
            inc_next  = inc1;
            son_next  = son1;
            code_next = down ? rsn_pkg::RAMP_FALL : up ? rsn_pkg::RAMP_UP :
                        fneed ? rsn_pkg::RAMP_SLEW : rsn_pkg::RAMP_IDLE;
            if (!son1)
                em_next = 1'b0;
            else if (!emit)
            begin
                if (!run_request && amp1 <= rsn_pkg::AMP_EPS)
                begin
                    son_next  = 1'b0;
                    amp_next  = '0;
                    code_next = rsn_pkg::RAMP_IDLE;
                end
                em_next = 1'b0;
            end
            else
                em_next = 1'b1;
        end
        else if (son_reg && em_reg)
        begin
            phase_next  = phase_reg + inc_reg;
            s1_next.rom = $signed(rsn_pkg::SINE_ROM[phase_next[31:24]]);
        end

        s1_next.env           = env_w[31:16];
        s1_next.output_active = son_next;
        s1_next.running       = em_next;
        s1_next.ramp_phase    = code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            inc_reg      <= '0;
            amp_reg      <= '0;
            son_reg      <= 1'b0;
            em_reg       <= 1'b0;
            code_reg     <= rsn_pkg::RAMP_IDLE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                inc_reg   <= inc_next;
                amp_reg   <= amp_next;
                son_reg   <= son_next;
                em_reg    <= em_next;
                code_reg  <= code_next;
            end
            if (advance)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s1_reg <= s1_next;
    end

    `RSN_ASSERT(a_amp_range, amp_reg <= rsn_pkg::AMP_ONE)
    `RSN_ASSERT(a_emit_needs_stream, !em_reg || son_reg)
    `RSN_ASSERT_NEXT(a_phase_hold, !(accept && !action && son_reg && em_reg), $stable(phase_reg))

endmodule

// ===== sv/rsn_scale.sv =====
// Envelope multiply and divide-by-32767 stages with the result register
`include "ramped_sine_nco_core_macros.svh"
module rsn_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                s1_valid,
    input  rsn_pkg::s1_t                        s1,
    output logic                                result_valid,
    output logic signed [rsn_pkg::SMP_W-1:0]    sample,
    output logic                                output_active,
    output logic                                running,
    output logic [1:0]                          ramp_phase
);

    logic                            s2_valid_reg;
    logic signed [31:0]              s2_prod_reg;
    logic                            s2_act_reg, s2_run_reg;
    logic [1:0]                      s2_code_reg;
    logic                            out_valid_reg;
    logic signed [rsn_pkg::SMP_W-1:0] out_smp_reg;
    logic                            out_act_reg, out_run_reg;
    logic [1:0]                      out_code_reg;

    logic [29:0]                     mag;
    logic [30:0]                     msum;
    logic [15:0]                     q0, q;
    logic [31:0]                     rem;
    logic signed [rsn_pkg::SMP_W-1:0] smp_next;

    assign result_valid  = out_valid_reg;
    assign sample        = out_smp_reg;
    assign output_active = out_act_reg;
    assign running       = out_run_reg;
    assign ramp_phase    = out_code_reg;

    // truncating divide of |prod| by 2^15-1: estimate, then one correction
    always_comb
    begin
        mag      = s2_prod_reg[31] ? 30'(-s2_prod_reg) : s2_prod_reg[29:0];
        msum     = {1'b0, mag} + {16'd0, mag[29:15]};
        q0       = msum[30:15];
        rem      = ({2'd0, mag} + {16'd0, q0}) - {1'b0, q0, 15'd0};
        q        = (rem >= rsn_pkg::ENV_FULL) ? (q0 + 16'd1) : q0;
        smp_next = s2_prod_reg[31] ? $signed(-q) : $signed(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_prod_reg  <= s1.rom * $signed({1'b0, s1.env});
            s2_act_reg   <= s1.output_active;
            s2_run_reg   <= s1.running;
            s2_code_reg  <= s1.ramp_phase;
            out_smp_reg  <= smp_next;
            out_act_reg  <= s2_act_reg;
            out_run_reg  <= s2_run_reg;
            out_code_reg <= s2_code_reg;
        end
    end

    `RSN_ASSERT(a_rem_range, !s2_valid_reg || (rem < (rsn_pkg::ENV_FULL + rsn_pkg::ENV_FULL)))
    `RSN_ASSERT_NEXT(a_zero_prod, advance && s1_valid && s1.rom == 16'sd0, s2_prod_reg == 32'sd0)
    `RSN_ASSERT(a_no_min_sample, !out_valid_reg || out_smp_reg != 16'sh8000)

endmodule

// ===== sv/ramped_sine_nco_core.sv =====
// Ramped sine NCO core: top level
// One transaction is accepted per clock cycle while the result is not stalled; each
// yields one result through the ramp/phase/sine-ROM stage, the envelope multiply
// stage and the divide by 32767 stage. Ramp ticks move amplitude and phase increment
// toward their targets by the programmed steps; running sample ticks advance the
// 32-bit phase and scale the ROM value. The whole pipeline holds while the result is
// stalled. Registers (APB, byte address): 0x0 rise_step, 0x4 fall_step, 0x8 inc_slew.
module ramped_sine_nco_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsn_pkg::ADDR_W-1:0]          paddr,
    input  logic [rsn_pkg::DATA_W-1:0]          pwdata,
    output logic [rsn_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                action,
    input  logic                                run_request,
    input  logic [rsn_pkg::PHASE_W-1:0]         goal_inc,
    input  logic [rsn_pkg::INT_W-1:0]           goal_level,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [rsn_pkg::SMP_W-1:0]    sample,
    output logic                                output_active,
    output logic                                running,
    output logic [1:0]                          ramp_phase
);

    rsn_pkg::cfg_t cfg;
    rsn_pkg::s1_t  s1;
    logic          s1_valid;
    logic          advance;
    logic          accept;

    assign advance    = !result_valid || !result_stall;
    assign item_stall = !advance;
    assign accept     = item_valid && advance;

    rsn_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsn_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .advance     (advance),
        .action      (action),
        .run_request (run_request),
        .goal_inc    (goal_inc),
        .goal_level  (goal_level),
        .s1_valid    (s1_valid),
        .s1          (s1)
    );

    rsn_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .s1_valid      (s1_valid),
        .s1            (s1),
        .result_valid  (result_valid),
        .sample        (sample),
        .output_active (output_active),
        .running       (running),
        .ramp_phase    (ramp_phase)
    );

endmodule
